@@ sv/pol_pkg.sv @@
// pol_pkg: shared constants for the positional ordered list
// operation and status codes, field widths and parameter defaults; no dependencies
package pol_pkg;

   localparam int DefaultCapacity  = 16;
   localparam int DefaultDataWidth = 32;

   localparam int OpWidth     = 3;
   localparam int PosWidth    = 5;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;
   localparam int CountWidth  = 5;

   localparam logic [OpWidth-1:0] OP_INSERT   = 3'd0;
   localparam logic [OpWidth-1:0] OP_DELETE   = 3'd1;
   localparam logic [OpWidth-1:0] OP_RETRIEVE = 3'd2;
   localparam logic [OpWidth-1:0] OP_REPLACE  = 3'd3;
   localparam logic [OpWidth-1:0] OP_CLEAR    = 3'd4;

   localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] ST_RANGE = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

endpackage

@@ sv/pol_ram.sv @@
// pol_ram: entry store of the positional ordered list
// one write port and one registered read port; uses pol_pkg for defaults
module pol_ram
   import pol_pkg::*;
#(
   parameter int DEPTH = DefaultCapacity,
   parameter int WIDTH = DefaultDataWidth,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/positional_ordered_list.sv @@
// positional_ordered_list: top level with request decode and move sequencer
// depends on pol_pkg and pol_ram
//
// Ordered list of up to CAPACITY entries with insert, delete, retrieve, replace and
// clear at a list position; every request beat gives one response beat with the
// value read, a status and the entry count. Entries live in a single-port-write,
// registered-read memory and a small sequencer moves them one at a time through that
// port, reading each moved entry and writing it back. An insert shifts the entries
// from the position up by one place and a delete shifts the later ones down; a clear
// or a rejected request moves nothing. req_tready is high only while the sequencer
// is idle; a finished response waits in an output register, so the next request can
// be taken before it is collected. No clearing pass follows reset.
module positional_ordered_list
   import pol_pkg::*;
#(
   parameter int CAPACITY   = DefaultCapacity,
   parameter int DATA_WIDTH = DefaultDataWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[4:0], value_in[36:5], zero[39:37]
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value_out[31:0], entry_count[36:32], zero[39:37]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > PosWidth) ? CW : PosWidth;
   localparam logic [CMPW-1:0] CapLimit = CMPW'(CAPACITY);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP     = 3'd1;
   localparam logic [2:0] S_UP_WR  = 3'd2;
   localparam logic [2:0] S_PUT    = 3'd3;
   localparam logic [2:0] S_GET_RD = 3'd4;
   localparam logic [2:0] S_GET    = 3'd5;
   localparam logic [2:0] S_DN     = 3'd6;
   localparam logic [2:0] S_DN_WR  = 3'd7;
   // response hand-off uses its own flag so the state stays three bits
   logic done_ff, done_in;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [OpWidth-1:0]    op_ff, op_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;
   logic [StatusWidth-1:0] status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [CountWidth-1:0] rsp_count_ff, rsp_count_in;

   logic [OpWidth-1:0]    req_op;
   logic [PosWidth-1:0]   req_pos;
   logic [ValueWidth-1:0] req_value;
   logic                  req_fire;
   logic [CMPW-1:0]       pos_ext, cnt_ext;

   logic [CW-1:0]         step;
   logic                  more;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic [63:0]           value_wide, result_wide;
   logic                  rsp_free;

   assign req_op    = req_tuser;
   assign req_pos   = req_tdata[4:0];
   assign req_value = req_tdata[36:5];
   assign req_tready = (state_ff == S_IDLE) && !done_ff;
   assign req_fire  = req_tvalid && req_tready;
   assign pos_ext   = CMPW'(req_pos);
   assign cnt_ext   = CMPW'(count_ff);
   assign value_wide = 64'(req_value);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // shared index unit: one step and one compare per cycle
   always_comb begin
      if (state_ff == S_UP || state_ff == S_UP_WR) begin
         step = idx_ff - CW'(1);
         more = idx_ff > pos_ff;
      end else begin
         step = idx_ff + CW'(1);
         more = step < count_ff;
      end
   end

   assign rd_addr = (state_ff == S_GET_RD) ? pos_ff[AW-1:0] : step[AW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[AW-1:0];
      wr_data = val_ff;
      case (state_ff)
         S_UP_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
         end
         S_DN_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
         end
         S_PUT: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   pol_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      result_in = result_ff;
      status_in = status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_op;
               pos_in    = CW'(pos_ext);
               val_in    = value_wide[DATA_WIDTH-1:0];
               result_in = '0;
               status_in = ST_OK;
               done_in   = 1'b1;
               case (req_op)
                  OP_INSERT: begin
                     if (cnt_ext == CapLimit) begin
                        status_in = ST_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        status_in = ST_RANGE;
                     end else begin
                        idx_in   = count_ff;
                        done_in  = 1'b0;
                        state_in = S_UP;
                     end
                  end
                  OP_DELETE, OP_RETRIEVE, OP_REPLACE: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = ST_RANGE;
                     end else begin
                        idx_in   = CW'(pos_ext);
                        done_in  = 1'b0;
                        state_in = (req_op == OP_REPLACE) ? S_PUT : S_GET_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end else if (done_ff && rsp_free) begin
               done_in = 1'b0;
            end
         end
         S_UP: begin
            state_in = more ? S_UP_WR : S_PUT;
         end
         S_UP_WR: begin
            idx_in   = step;
            state_in = S_UP;
         end
         S_PUT: begin
            if (op_ff == OP_INSERT) begin
               count_in = count_ff + CW'(1);
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_GET_RD: begin
            state_in = S_GET;
         end
         S_GET: begin
            result_in = rd_data;
            if (op_ff == OP_DELETE) begin
               state_in = S_DN;
            end else begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DN: begin
            if (more) begin
               state_in = S_DN_WR;
            end else begin
               count_in = count_ff - CW'(1);
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DN_WR: begin
            idx_in   = step;
            state_in = S_DN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result_wide = 64'(result_ff);

   // response register: loaded from the finished request when the slot is free
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_IDLE && done_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = result_wide[ValueWidth-1:0];
         rsp_status_in = status_ff;
         rsp_count_in  = CountWidth'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
